// File: rtl/clnum_pkg.sv
package clnum_pkg;

    // Longest literal the length counter can hold before it saturates.
    localparam int MAX_LITERAL_LENGTH = 255;
    localparam int LEN_W = $clog2(MAX_LITERAL_LENGTH + 1);

    // Scan phases. The two pending phases also say which byte is held back.
    typedef enum logic [3:0] {
        PH_FIRST0   = 4'd0,
        PH_DEC_INT  = 4'd1,
        PH_DOT_PEND = 4'd2,
        PH_DEC_FRAC = 4'd3,
        PH_LD_FRAC  = 4'd4,
        PH_EXP_SIGN = 4'd5,
        PH_EXP_DIG  = 4'd6,
        PH_HEX_INT  = 4'd7,
        PH_HEX_FRAC = 4'd8,
        PH_BIN      = 4'd9,
        PH_SUFFIX   = 4'd10,
        PH_SUFFIX_W = 4'd11
    } t_phase;

    typedef struct packed {
        logic             active;
        t_phase           phase;
        logic [LEN_W-1:0] count;
        logic             flt;
        logic             ovf;
    } t_scan_state;

    typedef struct packed {
        logic       too_long;
        logic [1:0] trailing;
        logic       float_lit;
        logic [7:0] length;
    } t_result;

endpackage

// File: rtl/clnum_step.sv
module clnum_step (
    input  clnum_pkg::t_scan_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_begin,
    input  logic                   i_last,
    output clnum_pkg::t_scan_state o_state,
    output logic                   o_done,
    output clnum_pkg::t_result     o_result
);
    import clnum_pkg::*;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_W  = 8'h77;
    localparam logic [7:0] CH_UP_W  = 8'h57;
    localparam logic [7:0] CH_LO_I  = 8'h69;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_UP_U  = 8'h55;
    localparam logic [7:0] CH_LO_L  = 8'h6C;
    localparam logic [7:0] CH_UP_L  = 8'h4C;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_F));
    endfunction

    function automatic logic is_sfx(input logic [7:0] c);
        return (c == CH_LO_U) || (c == CH_UP_U) || (c == CH_LO_L) || (c == CH_UP_L) ||
               (c == CH_LO_F) || (c == CH_UP_F) || (c == CH_LO_I);
    endfunction

    t_phase           ph;
    logic [1:0]       add;
    logic             flt;
    logic             done;
    logic             go;
    logic [1:0]       trail;
    logic [LEN_W-1:0] base;
    logic [LEN_W:0]   sum;
    logic [LEN_W-1:0] cnt;
    logic             ovf;
    logic [16:0]      cnt_ext;

    // The phase chain falls through at most three phases on one byte, for
    // example a zero prefix into decimal digits into the suffix check.
    always_comb begin
        ph    = i_state.phase;
        add   = 2'd0;
        flt   = i_state.flt;
        done  = 1'b0;
        go    = 1'b0;
        trail = 2'd0;
        base  = i_state.count;
        if (!i_state.active) begin
            base = '0;
            flt  = 1'b0;
            if (i_begin) begin
                add = 2'd1;
                if (i_byte == CH_0) begin
                    ph = PH_FIRST0;
                end else if (is_dec(i_byte)) begin
                    ph = PH_DEC_INT;
                end else if (i_byte == CH_DOT) begin
                    flt = 1'b1;
                    ph  = PH_LD_FRAC;
                end else begin
                    add   = 2'd0;
                    done  = 1'b1;
                    trail = 2'd1;
                end
            end
        end else begin
            go = 1'b1;
        end

        for (int i = 0; i < 4; i++) begin
            if (go) begin
                case (ph)
                    PH_FIRST0: begin
                        if (i_byte == CH_LO_X || i_byte == CH_UP_X) begin
                            add = add + 2'd1; ph = PH_HEX_INT; go = 1'b0;
                        end else if (i_byte == CH_LO_B || i_byte == CH_UP_B) begin
                            add = add + 2'd1; ph = PH_BIN; go = 1'b0;
                        end else begin
                            ph = PH_DEC_INT;
                        end
                    end
                    PH_DEC_INT, PH_DEC_FRAC: begin
                        if (is_dec(i_byte)) begin
                            add = add + 2'd1; go = 1'b0;
                        end else if (i_byte == CH_DOT) begin
                            ph = PH_DOT_PEND; go = 1'b0;
                        end else if (i_byte == CH_LO_E || i_byte == CH_UP_E) begin
                            add = add + 2'd1; flt = 1'b1; ph = PH_EXP_SIGN; go = 1'b0;
                        end else begin
                            ph = PH_SUFFIX;
                        end
                    end
                    PH_DOT_PEND: begin
                        if (i_byte == CH_DOT) begin
                            done = 1'b1; trail = 2'd2; go = 1'b0;
                        end else begin
                            add = add + 2'd1; flt = 1'b1; ph = PH_DEC_FRAC;
                        end
                    end
                    PH_LD_FRAC: begin
                        if (is_dec(i_byte)) begin
                            add = add + 2'd1; go = 1'b0;
                        end else if (i_byte == CH_LO_E || i_byte == CH_UP_E) begin
                            add = add + 2'd1; ph = PH_EXP_SIGN; go = 1'b0;
                        end else begin
                            ph = PH_SUFFIX;
                        end
                    end
                    PH_EXP_SIGN: begin
                        if (i_byte == CH_PLUS || i_byte == CH_MINUS) begin
                            add = add + 2'd1; ph = PH_EXP_DIG; go = 1'b0;
                        end else begin
                            ph = PH_EXP_DIG;
                        end
                    end
                    PH_EXP_DIG: begin
                        if (is_dec(i_byte)) begin
                            add = add + 2'd1; go = 1'b0;
                        end else begin
                            ph = PH_SUFFIX;
                        end
                    end
                    PH_HEX_INT: begin
                        if (is_hex(i_byte)) begin
                            add = add + 2'd1; go = 1'b0;
                        end else if (i_byte == CH_DOT) begin
                            add = add + 2'd1; flt = 1'b1; ph = PH_HEX_FRAC; go = 1'b0;
                        end else if (i_byte == CH_LO_P || i_byte == CH_UP_P) begin
                            add = add + 2'd1; flt = 1'b1; ph = PH_EXP_SIGN; go = 1'b0;
                        end else begin
                            ph = PH_SUFFIX;
                        end
                    end
                    PH_HEX_FRAC: begin
                        if (is_hex(i_byte)) begin
                            add = add + 2'd1; go = 1'b0;
                        end else if (i_byte == CH_LO_P || i_byte == CH_UP_P) begin
                            add = add + 2'd1; ph = PH_EXP_SIGN; go = 1'b0;
                        end else begin
                            ph = PH_SUFFIX;
                        end
                    end
                    PH_BIN: begin
                        if (i_byte == CH_0 || i_byte == CH_1) begin
                            add = add + 2'd1; go = 1'b0;
                        end else begin
                            ph = PH_SUFFIX;
                        end
                    end
                    PH_SUFFIX: begin
                        if (is_sfx(i_byte)) begin
                            add = add + 2'd1; go = 1'b0;
                        end else if (i_byte == CH_LO_W || i_byte == CH_UP_W) begin
                            ph = PH_SUFFIX_W; go = 1'b0;
                        end else begin
                            done = 1'b1; trail = 2'd1; go = 1'b0;
                        end
                    end
                    PH_SUFFIX_W: begin
                        if (i_byte == CH_LO_B || i_byte == CH_UP_B) begin
                            add = add + 2'd2; ph = PH_SUFFIX; go = 1'b0;
                        end else begin
                            done = 1'b1; trail = 2'd2; go = 1'b0;
                        end
                    end
                    default: begin
                        done = 1'b1; trail = 2'd1; go = 1'b0;
                    end
                endcase
            end
        end

        // End of input closes an open literal; a held dot joins it, a held w
        // is left outside.
        if ((i_state.active || i_begin) && !done && i_last) begin
            done = 1'b1;
            if (ph == PH_DOT_PEND) begin
                add = add + 2'd1;
                flt = 1'b1;
            end else if (ph == PH_SUFFIX_W) begin
                trail = 2'd1;
            end
        end
    end

    always_comb begin
        sum = {1'b0, base} + (LEN_W + 1)'(add);
        ovf = (i_state.active && i_state.ovf);
        if (sum > (LEN_W + 1)'(MAX_LITERAL_LENGTH)) begin
            cnt = LEN_W'(MAX_LITERAL_LENGTH);
            ovf = 1'b1;
        end else begin
            cnt = sum[LEN_W-1:0];
        end
        cnt_ext = 17'(cnt);
    end

    always_comb begin
        o_done             = done;
        o_result.length    = (cnt_ext > 17'd255) ? 8'hFF : cnt_ext[7:0];
        o_result.float_lit = flt;
        o_result.trailing  = trail;
        o_result.too_long  = ovf;
        if (done || (!i_state.active && !i_begin)) begin
            o_state.active = 1'b0;
            o_state.phase  = PH_FIRST0;
            o_state.count  = '0;
            o_state.flt    = 1'b0;
            o_state.ovf    = 1'b0;
        end else begin
            o_state.active = 1'b1;
            o_state.phase  = ph;
            o_state.count  = cnt;
            o_state.flt    = flt;
            o_state.ovf    = ovf;
        end
    end

endmodule

// File: rtl/c_number_literal_scanner_unit.sv
// A result is offered once the byte that ends the literal has been loaded into the input register
// and the scanner's report on it has then been loaded into the result register.
// Throughput: one source byte per cycle, sustained, as long as results are taken when offered.
// The per-byte scan is a short chain of character-class checks on the phase register.
// Reset (i_rst_n low at a rising edge, synchronous) empties both register stages and returns
// the scanner to idle with a cleared length count.
module c_number_literal_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Source bytes.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_req
    input  logic        i_s_axis_tuser,   // [0] begin_req
    input  logic        i_s_axis_tlast,   // last byte of the input
    // Literal reports.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] literal_length, [9:8] trailing_bytes,
                                          // [10] too_long, [15:11] zero
    output logic        o_m_axis_tuser    // [0] float_lit
);
    import clnum_pkg::*;

    // Input register: holds one accepted byte until the scanner consumes it.
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_begin;
    logic        r_last;

    // Scanner state, updated once per consumed byte.
    t_scan_state r_state;
    t_scan_state w_next_state;
    logic        w_done;
    t_result     w_result;

    // Result register.
    logic        r_out_valid;
    t_result     r_out;

    logic        w_proceed;

    // A byte is consumed whenever the result register can take a report this cycle,
    // so a waiting result never stops the input side unless it is stalled itself.
    assign w_proceed       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_proceed;

    clnum_step u_step (
        .i_state  (r_state),
        .i_byte   (r_byte),
        .i_begin  (r_begin),
        .i_last   (r_last),
        .o_state  (w_next_state),
        .o_done   (w_done),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_byte  <= i_s_axis_tdata;
            r_begin <= i_s_axis_tuser;
            r_last  <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.active <= 1'b0;
            r_state.phase  <= PH_FIRST0;
            r_state.count  <= '0;
            r_state.flt    <= 1'b0;
            r_state.ovf    <= 1'b0;
        end else if (w_proceed) begin
            r_state <= w_next_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed && w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && w_done) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.too_long, r_out.trailing, r_out.length};
    assign o_m_axis_tuser  = r_out.float_lit;

    // An idle scanner carries no leftover length or flags from the last literal.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.active |-> (r_state.count == '0) && !r_state.flt && !r_state.ovf)
        else $error("idle scanner holds stale literal state");

    // The length count never passes its saturation limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= LEN_W'(MAX_LITERAL_LENGTH))
        else $error("length count beyond limit");

    // Overflow is only recorded once the count has saturated.
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ovf |-> (r_state.count == LEN_W'(MAX_LITERAL_LENGTH)))
        else $error("overflow flag without saturated count");

    // A finished literal always reaches the result register on the next edge.
    a_done_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proceed && w_done) |=> r_out_valid)
        else $error("literal report lost");

    // At most two bytes can lie outside a literal.
    a_trail_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.trailing != 2'd3))
        else $error("trailing byte count out of range");

endmodule
